/* rtl/core/trq_pkg.sv */
// Shared types and codes for the timestamp ring queue.
package trq_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CAP_W     = 7;
	localparam int unsigned STATUS_W  = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_START = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_SIZE  = 2'd3;

	// Operation codes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;

	localparam logic [DATA_W-1:0] PTS_NONE = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [DATA_W-1:0] pts;
		logic [DATA_W-1:0] start;
		logic [DATA_W-1:0] length;
	} entry_t;

endpackage

/* rtl/core/trq_mem.sv */
// Entry memory: one write port, one read port, registered read data.
module trq_mem #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  trq_pkg::entry_t          wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output trq_pkg::entry_t          rd_data
);

	trq_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/core/trq_match.sv */
// Range test of one entry against a folded position in the circular supply buffer.
module trq_match (
	input  trq_pkg::entry_t              entry,
	input  logic [trq_pkg::DATA_W-1:0]   pos,
	input  logic [trq_pkg::DATA_W-1:0]   buf_end,
	input  logic [trq_pkg::DATA_W-1:0]   supply_start,
	input  logic [trq_pkg::DATA_W-1:0]   supply_size,
	output logic                         hit
);

	logic [trq_pkg::DATA_W-1:0] end_addr;
	logic [trq_pkg::DATA_W-1:0] end_wrapped;
	logic                       in_head;
	logic                       in_tail;

	always_comb begin
		end_addr    = entry.start + entry.length;
		end_wrapped = entry.start + entry.length - supply_size;
		in_head     = (entry.start <= pos) && (pos < buf_end);
		in_tail     = (supply_start <= pos) && (pos < end_wrapped);
		// a range past the buffer end continues at the buffer start
		if (end_addr <= buf_end) begin
			hit = (entry.start <= pos) && (pos < end_addr);
		end else begin
			hit = in_head || in_tail;
		end
	end

endmodule

/* rtl/core/timestamp_ring_queue_range_lookup.sv */
// Timestamp ring queue with range lookup over a circular supply buffer.
//
// Input channel (in_valid / in_stall) carries one transaction: a write that
// appends {entry_pts, entry_start, entry_size}, or a lookup of a byte position.
// Output channel (out_valid / out_stall) returns exactly one result per input.
// A lookup drops the entries ahead of the first covering entry and returns it.
// Configuration is a plain write port (cfg_write_en, cfg_index, cfg_data);
// writing the enable or capacity register empties the queue.
//
// Sequence: writes, refused and ignored transactions and lookups on an empty
// queue pass from acceptance straight to the finish state. A lookup reads the
// entry memory one entry per cycle from the head in the scan state, tests each
// read entry, and goes to the finish state on the first match or after the last
// stored entry (at most QUEUE_DEPTH). From the finish state the result moves to
// the output register once it is free. One transaction is in work at a time:
// the next is taken the cycle after the result moves to the output register.
// The output register holds its result while out_stall is high; a new
// transaction is still accepted and runs up to its result meanwhile.
// Reset empties the queue, disables it, and sets capacity to 64; the entry
// memory is not cleared.
module timestamp_ring_queue_range_lookup #(
	parameter int unsigned QUEUE_DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write_en,
	input  logic [trq_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [trq_pkg::DATA_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 opcode,
	input  logic signed [trq_pkg::DATA_W-1:0]    entry_pts,
	input  logic [trq_pkg::DATA_W-1:0]           entry_start,
	input  logic [trq_pkg::DATA_W-1:0]           entry_size,
	input  logic [trq_pkg::DATA_W-1:0]           position,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 found,
	output logic signed [trq_pkg::DATA_W-1:0]    pts_out,
	output logic [trq_pkg::DATA_W-1:0]           start_out,
	output logic [trq_pkg::DATA_W-1:0]           size_out,
	output logic                                 queue_full,
	output logic [trq_pkg::STATUS_W-1:0]         status
);

	localparam int unsigned PW = $clog2(QUEUE_DEPTH);
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	typedef struct packed {
		logic                          found;
		logic [trq_pkg::DATA_W-1:0]    pts;
		logic [trq_pkg::DATA_W-1:0]    start;
		logic [trq_pkg::DATA_W-1:0]    size;
		logic                          full;
		logic [trq_pkg::STATUS_W-1:0]  status;
	} result_t;

	// configuration
	logic                         enable_q;
	logic [trq_pkg::CAP_W-1:0]    cap_q;
	logic [trq_pkg::DATA_W-1:0]   supply_start_q;
	logic [trq_pkg::DATA_W-1:0]   supply_size_q;

	// queue control
	logic [1:0]    st_q;
	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [CW-1:0] count_q;

	// scan
	logic [PW-1:0]              rd_idx_q;
	logic [CW-1:0]              issue_k_q;
	logic                       eval_valid_s1;
	logic [PW-1:0]              eval_idx_s1;
	logic [CW-1:0]              eval_k_s1;
	logic [trq_pkg::DATA_W-1:0] pos_q;
	logic [trq_pkg::DATA_W-1:0] buf_end_q;

	result_t res_q;
	result_t out_q;
	logic    out_valid_q;

	logic [31:0]                cap_wide;
	logic [CW-1:0]              cap_eff;
	logic [trq_pkg::DATA_W-1:0] buf_end;
	logic [trq_pkg::DATA_W-1:0] pos_fold;
	logic                       in_acc;
	logic                       out_free;
	logic                       full_now;
	logic                       cfg_clear;
	logic                       wr_ok;
	logic                       issue;
	logic                       hit;
	logic                       last;
	logic                       resolve;
	logic [CW-1:0]              count_left;
	trq_pkg::entry_t            wr_entry;
	trq_pkg::entry_t            rd_entry;
	result_t                    acc_res;

	function automatic logic [PW-1:0] next_idx(input logic [PW-1:0] idx,
			input logic [CW-1:0] cap);
		logic [CW-1:0] inc;
		inc = CW'(idx) + CW'(1);
		return (inc == cap) ? '0 : PW'(inc);
	endfunction

	always_comb begin
		cap_wide = (cap_q == '0) ? 32'd1 : 32'(cap_q);
		if (cap_wide > 32'(QUEUE_DEPTH)) begin
			cap_wide = 32'(QUEUE_DEPTH);
		end
		cap_eff = CW'(cap_wide);
	end

	always_comb begin
		buf_end    = supply_start_q + supply_size_q;
		pos_fold   = (position >= buf_end) ? position - supply_size_q : position;
		in_stall   = (st_q != ST_IDLE);
		in_acc     = in_valid && !in_stall;
		out_free   = !out_valid_q || !out_stall;
		full_now   = (count_q >= cap_eff);
		cfg_clear  = cfg_write_en &&
			((cfg_index == trq_pkg::REG_ENABLE) || (cfg_index == trq_pkg::REG_CAPACITY));
		wr_ok      = in_acc && enable_q && (opcode == trq_pkg::OP_WRITE) &&
			!entry_pts[trq_pkg::DATA_W-1] && !full_now;
		wr_entry.pts    = entry_pts;
		wr_entry.start  = entry_start;
		wr_entry.length = entry_size;
		last       = (eval_k_s1 == count_q - CW'(1));
		resolve    = (st_q == ST_SCAN) && eval_valid_s1 && (hit || last);
		issue      = (st_q == ST_SCAN) && !resolve && (issue_k_q < count_q);
		count_left = count_q - eval_k_s1;
	end

	// result of a transaction that finishes in the acceptance cycle
	always_comb begin
		acc_res.found  = 1'b0;
		acc_res.pts    = trq_pkg::PTS_NONE;
		acc_res.start  = '0;
		acc_res.size   = '0;
		acc_res.full   = full_now;
		acc_res.status = trq_pkg::STATUS_OK;
		if (!enable_q) begin
			acc_res.full   = 1'b0;
			acc_res.status = trq_pkg::STATUS_IGNORED;
		end else if (opcode == trq_pkg::OP_WRITE) begin
			if (entry_pts[trq_pkg::DATA_W-1]) begin
				acc_res.status = trq_pkg::STATUS_IGNORED;
			end else if (full_now) begin
				acc_res.status = trq_pkg::STATUS_REFUSED;
			end else begin
				acc_res.full = ((count_q + CW'(1)) >= cap_eff);
			end
		end
	end

	trq_mem #(
		.DEPTH(QUEUE_DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_ok),
		.wr_addr (tail_q),
		.wr_data (wr_entry),
		.rd_en   (issue),
		.rd_addr (rd_idx_q),
		.rd_data (rd_entry)
	);

	trq_match u_match (
		.entry        (rd_entry),
		.pos          (pos_q),
		.buf_end      (buf_end_q),
		.supply_start (supply_start_q),
		.supply_size  (supply_size_q),
		.hit          (hit)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q       <= 1'b0;
			cap_q          <= 7'd64;
			supply_start_q <= '0;
			supply_size_q  <= '0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				trq_pkg::REG_ENABLE:       enable_q       <= cfg_data[0];
				trq_pkg::REG_CAPACITY:     cap_q          <= cfg_data[trq_pkg::CAP_W-1:0];
				trq_pkg::REG_SUPPLY_START: supply_start_q <= cfg_data;
				trq_pkg::REG_SUPPLY_SIZE:  supply_size_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer, queue pointers and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_IDLE;
			head_q        <= '0;
			tail_q        <= '0;
			count_q       <= '0;
			rd_idx_q      <= '0;
			issue_k_q     <= '0;
			eval_valid_s1 <= 1'b0;
			eval_idx_s1   <= '0;
			eval_k_s1     <= '0;
		end else begin
			eval_valid_s1 <= issue;
			if (issue) begin
				eval_idx_s1 <= rd_idx_q;
				eval_k_s1   <= issue_k_q;
				rd_idx_q    <= next_idx(rd_idx_q, cap_eff);
				issue_k_q   <= issue_k_q + CW'(1);
			end
			case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (enable_q && (opcode == trq_pkg::OP_LOOKUP) && (count_q != '0)) begin
							rd_idx_q  <= head_q;
							issue_k_q <= '0;
							st_q      <= ST_SCAN;
						end else begin
							st_q <= ST_FIN;
						end
						if (wr_ok) begin
							tail_q  <= next_idx(tail_q, cap_eff);
							count_q <= count_q + CW'(1);
						end
					end
				end
				ST_SCAN: begin
					if (resolve) begin
						// drop the entries ahead of the match
						if (hit) begin
							head_q  <= eval_idx_s1;
							count_q <= count_left;
						end
						st_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			if (cfg_clear) begin
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end
		end
	end

	// lookup operands and pending result
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pos_q     <= pos_fold;
			buf_end_q <= buf_end;
			res_q     <= acc_res;
		end
		if (resolve) begin
			res_q.found  <= hit;
			res_q.pts    <= hit ? rd_entry.pts : trq_pkg::PTS_NONE;
			res_q.start  <= hit ? rd_entry.start : '0;
			res_q.size   <= hit ? rd_entry.length : '0;
			res_q.full   <= hit ? (count_left >= cap_eff) : full_now;
			res_q.status <= trq_pkg::STATUS_OK;
		end
		if ((st_q == ST_FIN) && out_free) begin
			out_q <= res_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((st_q == ST_FIN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = out_q.found;
	assign pts_out    = out_q.pts;
	assign start_out  = out_q.start;
	assign size_out   = out_q.size;
	assign queue_full = out_q.full;
	assign status     = out_q.status;

endmodule

/* rtl/core/trq_checker.sv */
// Port-level checks for the timestamp ring queue, bound to the top level.
module trq_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic                               found,
	input logic signed [trq_pkg::DATA_W-1:0]  pts_out,
	input logic [trq_pkg::DATA_W-1:0]         start_out,
	input logic [trq_pkg::DATA_W-1:0]         size_out,
	input logic                               queue_full,
	input logic [trq_pkg::STATUS_W-1:0]       status
);

	// a match is only ever reported with good status
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> status == trq_pkg::STATUS_OK)
		else $error("match reported with non-ok status");

	// no match carries the empty entry
	a_miss_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |->
			pts_out == trq_pkg::PTS_NONE && start_out == '0 && size_out == '0)
		else $error("miss result carries entry data");

	// a refused write only happens on a full queue
	a_refused_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == trq_pkg::STATUS_REFUSED |-> queue_full && !found)
		else $error("write refused while queue not full");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == trq_pkg::STATUS_OK || status == trq_pkg::STATUS_REFUSED ||
			status == trq_pkg::STATUS_IGNORED)
		else $error("undefined status code");

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pts_out) && $stable(status))
		else $error("stalled result changed");

endmodule

bind timestamp_ring_queue_range_lookup trq_checker u_trq_checker (.*);

/* sim/timestamp_ring_queue_range_lookup_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the timestamp ring queue with range lookup.
module timestamp_ring_queue_range_lookup_test;

	localparam int unsigned DEPTH = 64;

	typedef struct {
		logic        op;
		logic [31:0] pts;
		logic [31:0] start;
		logic [31:0] size;
		logic [31:0] pos;
	} request_t;

	typedef struct {
		logic                         found;
		logic [31:0]                  pts;
		logic [31:0]                  start;
		logic [31:0]                  size;
		logic                         full;
		logic [trq_pkg::STATUS_W-1:0] status;
	} reply_t;

	typedef struct {
		bit                            is_cfg;
		logic [trq_pkg::CFG_IDX_W-1:0] reg_idx;
		logic [31:0]                   reg_val;
		request_t                      req;
		bit                            pinned;
		reply_t                        want;
	} plan_row_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_write_en = 1'b0;
	logic [trq_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
	logic [trq_pkg::DATA_W-1:0]          cfg_data = '0;
	logic                                in_valid = 1'b0;
	logic                                in_stall;
	logic                                opcode = trq_pkg::OP_WRITE;
	logic signed [trq_pkg::DATA_W-1:0]   entry_pts = '0;
	logic [trq_pkg::DATA_W-1:0]          entry_start = '0;
	logic [trq_pkg::DATA_W-1:0]          entry_size = '0;
	logic [trq_pkg::DATA_W-1:0]          position = '0;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic                                found;
	logic signed [trq_pkg::DATA_W-1:0]   pts_out;
	logic [trq_pkg::DATA_W-1:0]          start_out;
	logic [trq_pkg::DATA_W-1:0]          size_out;
	logic                                queue_full;
	logic [trq_pkg::STATUS_W-1:0]        status;

	// Mirror of the queue and its registers
	logic [31:0] slot_pts [DEPTH];
	logic [31:0] slot_start [DEPTH];
	logic [31:0] slot_len [DEPTH];
	int unsigned head_slot = 0;
	int unsigned tail_slot = 0;
	int unsigned fill_count = 0;
	logic        cfg_en = 1'b0;
	logic [6:0]  cfg_cap = 7'd64;
	logic [31:0] buf_base = '0;
	logic [31:0] buf_span = '0;

	reply_t      expected_replies [$];
	plan_row_t   plan [$];
	int unsigned mismatches = 0;
	bit          quiet = 1'b0;
	logic [31:0] feed_addr = '0;
	logic [31:0] pts_clock = '0;

	timestamp_ring_queue_range_lookup #(
		.QUEUE_DEPTH(DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.entry_pts    (entry_pts),
		.entry_start  (entry_start),
		.entry_size   (entry_size),
		.position     (position),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.found        (found),
		.pts_out      (pts_out),
		.start_out    (start_out),
		.size_out     (size_out),
		.queue_full   (queue_full),
		.status       (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int unsigned live_cap();
		if (cfg_cap == 7'd0) return 1;
		if (cfg_cap > DEPTH) return DEPTH;
		return cfg_cap;
	endfunction

	// Range test with support for ranges that run past the buffer end
	function automatic bit range_holds(input logic [31:0] data, input logic [31:0] len,
			input logic [31:0] pos, input logic [31:0] bend);
		logic [31:0] stop;
		stop = data + len;
		if (stop <= bend) return (data <= pos) && (pos < stop);
		return ((data <= pos) && (pos < bend)) || ((buf_base <= pos) && (pos < stop - buf_span));
	endfunction

	function automatic reply_t predict_reply(input request_t r);
		reply_t      rep;
		logic [31:0] bend;
		logic [31:0] p;
		int unsigned cap;
		int unsigned idx;
		int unsigned k;
		bit          hit;
		rep.found = 1'b0;
		rep.pts = trq_pkg::PTS_NONE;
		rep.start = '0;
		rep.size = '0;
		rep.full = 1'b0;
		rep.status = trq_pkg::STATUS_OK;
		cap = live_cap();
		if (!cfg_en) begin
			rep.status = trq_pkg::STATUS_IGNORED;
			return rep;
		end
		if (r.op == trq_pkg::OP_WRITE) begin
			if (r.pts[31]) begin
				rep.status = trq_pkg::STATUS_IGNORED;
			end else if (fill_count >= cap) begin
				rep.status = trq_pkg::STATUS_REFUSED;
			end else begin
				idx = (tail_slot < cap) ? tail_slot : tail_slot - cap;
				slot_pts[idx] = r.pts;
				slot_start[idx] = r.start;
				slot_len[idx] = r.size;
				tail_slot = (idx + 1 < cap) ? idx + 1 : idx + 1 - cap;
				fill_count++;
			end
			rep.full = (fill_count >= cap);
			return rep;
		end
		bend = buf_base + buf_span;
		p = r.pos;
		// fold the position once into the buffer
		if (p >= bend) p = p - buf_span;
		idx = (head_slot < cap) ? head_slot : head_slot - cap;
		hit = 1'b0;
		for (k = 0; !hit && k < fill_count && k < cap; k++) begin
			if (range_holds(slot_start[idx], slot_len[idx], p, bend)) begin
				hit = 1'b1;
				fill_count = fill_count - k;
				head_slot = idx;
				rep.found = 1'b1;
				rep.pts = slot_pts[idx];
				rep.start = slot_start[idx];
				rep.size = slot_len[idx];
			end else begin
				idx = (idx + 1 < cap) ? idx + 1 : idx + 1 - cap;
			end
		end
		rep.full = (fill_count >= cap);
		return rep;
	endfunction

	function automatic plan_row_t reg_row(input logic [trq_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] val);
		plan_row_t row;
		row = op_row(trq_pkg::OP_WRITE, '0, '0, '0, '0);
		row.is_cfg = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		return row;
	endfunction

	function automatic plan_row_t op_row(input logic op, input logic [31:0] pts,
			input logic [31:0] start, input logic [31:0] size, input logic [31:0] pos);
		plan_row_t row;
		row.is_cfg = 1'b0;
		row.reg_idx = trq_pkg::REG_ENABLE;
		row.reg_val = '0;
		row.req.op = op;
		row.req.pts = pts;
		row.req.start = start;
		row.req.size = size;
		row.req.pos = pos;
		row.pinned = 1'b0;
		row.want.found = 1'b0;
		row.want.pts = trq_pkg::PTS_NONE;
		row.want.start = '0;
		row.want.size = '0;
		row.want.full = 1'b0;
		row.want.status = trq_pkg::STATUS_OK;
		return row;
	endfunction

	function automatic plan_row_t pin(input plan_row_t row, input logic fnd, input logic [31:0] pts,
			input logic [31:0] start, input logic [31:0] size, input logic full,
			input logic [trq_pkg::STATUS_W-1:0] st);
		plan_row_t res;
		res = row;
		res.pinned = 1'b1;
		res.want.found = fnd;
		res.want.pts = pts;
		res.want.start = start;
		res.want.size = size;
		res.want.full = full;
		res.want.status = st;
		return res;
	endfunction

	function automatic request_t make_request(input int unsigned write_pct);
		request_t    r;
		int unsigned roll;
		int unsigned cap;
		int unsigned k;
		int unsigned slot;
		roll = $urandom_range(99);
		r.op = ($urandom_range(99) < write_pct) ? trq_pkg::OP_WRITE : trq_pkg::OP_LOOKUP;
		r.pts = $urandom;
		r.start = $urandom;
		r.size = $urandom;
		r.pos = $urandom;
		// leave raw noise as drawn
		if (roll < 12) return r;
		if (r.op == trq_pkg::OP_WRITE) begin
			pts_clock = pts_clock + $urandom_range(1, 3000);
			r.pts = {1'b0, pts_clock[30:0]};
			if (roll < 17) r.pts[31] = 1'b1;
			r.start = feed_addr;
			r.size = (roll < 20) ? 32'd0 : 32'($urandom_range(1, 48));
			// advance the fill address and wrap it at the buffer end
			feed_addr = feed_addr + r.size;
			if (feed_addr - buf_base >= buf_span) feed_addr = feed_addr - buf_span;
		end else if (fill_count != 0 && roll < 88) begin
			cap = live_cap();
			if (roll < 50)
				k = $urandom_range(0, (fill_count > 3) ? 3 : fill_count - 1);
			else
				k = $urandom_range(0, fill_count - 1);
			slot = (head_slot + k) % cap;
			r.pos = slot_start[slot];
			if (slot_len[slot] != 0) r.pos = r.pos + $urandom_range(0, slot_len[slot] - 1);
			if (roll > 80) r.pos = r.pos + buf_span;
		end else begin
			r.pos = feed_addr + $urandom_range(0, 63);
		end
		return r;
	endfunction

	task automatic write_reg(input logic [trq_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			trq_pkg::REG_ENABLE: begin
				cfg_en = val[0];
				head_slot = 0;
				tail_slot = 0;
				fill_count = 0;
			end
			trq_pkg::REG_CAPACITY: begin
				cfg_cap = val[6:0];
				head_slot = 0;
				tail_slot = 0;
				fill_count = 0;
			end
			trq_pkg::REG_SUPPLY_START: buf_base = val;
			trq_pkg::REG_SUPPLY_SIZE: buf_span = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_write_en <= 1'b0;
		@(negedge clk);
	endtask

	// Drop valid and wait until every reply has come back
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic issue(input request_t r, input bit pinned, input reply_t fixed,
			output reply_t pred);
		while (!quiet && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= r.op;
		entry_pts <= r.pts;
		entry_start <= r.start;
		entry_size <= r.size;
		position <= r.pos;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pred = predict_reply(r);
		expected_replies.push_back(pinned ? fixed : pred);
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(negedge clk) begin
		out_stall <= !quiet && ($urandom_range(99) < 32);
	end

	always @(posedge clk) begin : reply_check
		reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_replies.size() == 0) begin
				$display("%0t: result with none expected: found %b pts %h status %0d",
					$time, found, pts_out, status);
				mismatches++;
			end else begin
				want = expected_replies.pop_front();
				check_field("found", 32'(want.found), 32'(found));
				check_field("pts_out", want.pts, pts_out);
				check_field("start_out", want.start, start_out);
				check_field("size_out", want.size, size_out);
				check_field("queue_full", 32'(want.full), 32'(queue_full));
				check_field("status", 32'(want.status), 32'(status));
			end
		end
	end

	initial begin
		request_t    r;
		reply_t      rep;
		int unsigned counted;
		int unsigned phase;
		int unsigned n;
		int unsigned write_pct;
		logic [31:0] en_val;
		logic [31:0] cap_val;
		logic [31:0] base_val;
		logic [31:0] span_val;

		// Disabled after reset: everything is ignored
		plan.push_back(pin(op_row(trq_pkg::OP_WRITE, 32'd5, 32'd0, 32'd0, 32'd0),
			1'b0, trq_pkg::PTS_NONE, 32'd0, 32'd0, 1'b0, trq_pkg::STATUS_IGNORED));
		plan.push_back(pin(op_row(trq_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 32'd0, 32'd0,
			32'hFFFF_FFFF),
			1'b0, trq_pkg::PTS_NONE, 32'd0, 32'd0, 1'b0, trq_pkg::STATUS_IGNORED));
		// Capacity zero behaves as a single slot
		plan.push_back(reg_row(trq_pkg::REG_ENABLE, 32'd1));
		plan.push_back(reg_row(trq_pkg::REG_CAPACITY, 32'd0));
		plan.push_back(reg_row(trq_pkg::REG_SUPPLY_START, 32'h0000_1000));
		plan.push_back(reg_row(trq_pkg::REG_SUPPLY_SIZE, 32'h0000_0100));
		plan.push_back(pin(op_row(trq_pkg::OP_WRITE, 32'h7FFF_FFFF, 32'h1000, 32'h10, 32'd0),
			1'b0, trq_pkg::PTS_NONE, 32'd0, 32'd0, 1'b1, trq_pkg::STATUS_OK));
		plan.push_back(pin(op_row(trq_pkg::OP_WRITE, 32'd1, 32'h2000, 32'd4, 32'd0),
			1'b0, trq_pkg::PTS_NONE, 32'd0, 32'd0, 1'b1, trq_pkg::STATUS_REFUSED));
		plan.push_back(pin(op_row(trq_pkg::OP_WRITE, 32'h8000_0000, 32'h2000, 32'd4, 32'd0),
			1'b0, trq_pkg::PTS_NONE, 32'd0, 32'd0, 1'b1, trq_pkg::STATUS_IGNORED));
		plan.push_back(pin(op_row(trq_pkg::OP_LOOKUP, 32'd0, 32'd0, 32'd0, 32'h1005),
			1'b1, 32'h7FFF_FFFF, 32'h1000, 32'h10, 1'b1, trq_pkg::STATUS_OK));
		plan.push_back(pin(op_row(trq_pkg::OP_LOOKUP, 32'd0, 32'd0, 32'd0, 32'h1010),
			1'b0, trq_pkg::PTS_NONE, 32'd0, 32'd0, 1'b1, trq_pkg::STATUS_OK));
		// Oversized capacity acts as the full depth; ranges that wrap the buffer
		plan.push_back(reg_row(trq_pkg::REG_CAPACITY, 32'd127));
		plan.push_back(op_row(trq_pkg::OP_WRITE, 32'd0, 32'd0, 32'd0, 32'd0));
		plan.push_back(op_row(trq_pkg::OP_WRITE, 32'd100, 32'h1000, 32'h40, 32'd0));
		plan.push_back(op_row(trq_pkg::OP_WRITE, 32'd200, 32'h1040, 32'h40, 32'd0));
		plan.push_back(op_row(trq_pkg::OP_WRITE, 32'd300, 32'h10F0, 32'h20, 32'd0));
		plan.push_back(op_row(trq_pkg::OP_WRITE, 32'd400, 32'hFFFF_FFF0, 32'hFFFF_FFFF,
			32'd0));
		plan.push_back(op_row(trq_pkg::OP_LOOKUP, 32'd0, 32'd0, 32'd0, 32'h1050));
		plan.push_back(op_row(trq_pkg::OP_LOOKUP, 32'd0, 32'd0, 32'd0, 32'h1105));
		plan.push_back(op_row(trq_pkg::OP_LOOKUP, 32'd0, 32'd0, 32'd0, 32'h10F8));
		plan.push_back(op_row(trq_pkg::OP_LOOKUP, 32'd0, 32'd0, 32'd0, 32'h1020));
		plan.push_back(op_row(trq_pkg::OP_LOOKUP, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF));
		// Buffer at the top of the address space
		plan.push_back(reg_row(trq_pkg::REG_SUPPLY_START, 32'hFFFF_FFFF));
		plan.push_back(reg_row(trq_pkg::REG_SUPPLY_SIZE, 32'hFFFF_FFFF));
		plan.push_back(op_row(trq_pkg::OP_WRITE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'd0));
		plan.push_back(op_row(trq_pkg::OP_LOOKUP, 32'd0, 32'd0, 32'd0, 32'd0));
		plan.push_back(op_row(trq_pkg::OP_LOOKUP, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFE));
		plan.push_back(op_row(trq_pkg::OP_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'd0));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				issue(plan[i].req, plan[i].pinned, plan[i].want, rep);
			end
		end

		counted = 0;
		phase = 0;
		while (counted < 850) begin
			settle();
			// keep the stall-free phase enabled
			en_val = ($urandom_range(9) == 0 && phase > 4) ? 32'd0 : 32'd1;
			if ($urandom_range(1)) en_val = en_val | ($urandom & 32'hFFFF_FFFE);
			case (phase)
				0: cap_val = 32'd64;
				1: cap_val = 32'd1;
				2: cap_val = 32'd127;
				default: begin
					case ($urandom_range(5))
						0: cap_val = 32'd0;
						1: cap_val = 32'd2;
						2: cap_val = 32'd64;
						3: cap_val = $urandom_range(65, 127);
						default: cap_val = $urandom_range(3, 63);
					endcase
					if ($urandom_range(1)) cap_val = cap_val | ($urandom & 32'hFFFF_FF80);
				end
			endcase
			case ($urandom_range(5))
				0: base_val = 32'd0;
				1: base_val = 32'hFFFF_FFFF - $urandom_range(0, 255);
				default: base_val = $urandom;
			endcase
			case ($urandom_range(5))
				0: span_val = 32'd0;
				1: span_val = 32'hFFFF_FFFF;
				default: span_val = $urandom_range(64, 4096);
			endcase
			if (phase == 0) begin
				base_val = 32'h0001_0000;
				span_val = 32'd4096;
			end
			write_reg(trq_pkg::REG_ENABLE, en_val);
			write_reg(trq_pkg::REG_CAPACITY, cap_val);
			write_reg(trq_pkg::REG_SUPPLY_START, base_val);
			write_reg(trq_pkg::REG_SUPPLY_SIZE, span_val);
			feed_addr = buf_base + $urandom_range(0, 15);
			quiet = (phase == 4);
			case ($urandom_range(2))
				0: write_pct = 35;
				1: write_pct = 55;
				default: write_pct = 75;
			endcase
			if (phase == 0) write_pct = 97;
			n = cfg_en ? $urandom_range(40, 110) : $urandom_range(4, 10);
			repeat (n) begin
				r = make_request(write_pct);
				issue(r, 1'b0, rep, rep);
				if (rep.status != trq_pkg::STATUS_IGNORED) counted++;
			end
			phase++;
		end
		quiet = 1'b0;

		settle();
		repeat (80) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
